// ===== design/mks_pkg.sv =====
`default_nettype none

package mks_pkg;

	// func field codes
	localparam logic [1:0] FUNC_SCAN  = 2'd0;
	localparam logic [1:0] FUNC_POP   = 2'd1;
	localparam logic [1:0] FUNC_CLEAR = 2'd2;

	// configuration register indexes
	localparam logic REG_INITIAL_DELAY   = 1'b0;
	localparam logic REG_REPEAT_INTERVAL = 1'b1;

	localparam logic [7:0] INITIAL_DELAY_RESET   = 8'd16;
	localparam logic [7:0] REPEAT_INTERVAL_RESET = 8'd4;

	// history value for "no key held"
	localparam logic [7:0] NO_KEY   = 8'hFF;
	localparam logic [7:0] JOY_IDLE = 8'hFF;
	localparam logic [7:0] ROW_IDLE = 8'hFF;

	// matrix positions the joystick maps onto
	localparam logic [5:0] JOY_POS_UPDOWN    = 6'h07;
	localparam logic [5:0] JOY_POS_LEFTRIGHT = 6'h02;
	localparam logic [5:0] JOY_POS_FIRE      = 6'h01;
	localparam logic [2:0] MOD_SHIFT         = 3'h1;
	localparam logic [2:0] MOD_NONE          = 3'h0;

	typedef enum logic [2:0] {
		CMD_NOP,
		CMD_FORGET,
		CMD_KEY,
		CMD_POP,
		CMD_CLEAR
	} cmd_t;

	// one classified beat between front and back
	typedef struct packed {
		cmd_t       cmd;
		logic [5:0] pos;
		logic [2:0] mods;
		logic [7:0] code;
	} entry_t;

	localparam logic [2:0] MOD_BITS [64] = '{
		3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0,
		3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd1,
		3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0,
		3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0,
		3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0,
		3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0,
		3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd0, 3'd0, 3'd0,
		3'd0, 3'd0, 3'd4, 3'd0, 3'd0, 3'd2, 3'd0, 3'd0
	};

	localparam logic [7:0] PLAIN_CODES [64] = '{
		8'h14, 8'h0D, 8'h1D, 8'h88, 8'h85, 8'h86, 8'h87, 8'h11,
		8'h33, 8'h77, 8'h61, 8'h34, 8'h7A, 8'h73, 8'h65, 8'h00,
		8'h35, 8'h72, 8'h64, 8'h36, 8'h63, 8'h66, 8'h74, 8'h78,
		8'h37, 8'h79, 8'h67, 8'h38, 8'h62, 8'h68, 8'h75, 8'h76,
		8'h39, 8'h69, 8'h6A, 8'h30, 8'h6D, 8'h6B, 8'h6F, 8'h6E,
		8'h2B, 8'h70, 8'h6C, 8'h2D, 8'h2E, 8'h3A, 8'h40, 8'h2C,
		8'h5C, 8'h2A, 8'h3B, 8'h13, 8'h01, 8'h3D, 8'h7C, 8'h2F,
		8'h31, 8'h60, 8'h00, 8'h32, 8'h20, 8'h00, 8'h71, 8'h03
	};

	localparam logic [7:0] SHIFT_CODES [64] = '{
		8'h94, 8'h8D, 8'h9D, 8'h8C, 8'h89, 8'h8A, 8'h8B, 8'h91,
		8'h23, 8'h57, 8'h41, 8'h24, 8'h5A, 8'h53, 8'h45, 8'h00,
		8'h25, 8'h52, 8'h44, 8'h26, 8'h43, 8'h46, 8'h54, 8'h58,
		8'h27, 8'h59, 8'h47, 8'h28, 8'h42, 8'h48, 8'h55, 8'h56,
		8'h29, 8'h49, 8'h4A, 8'h30, 8'h4D, 8'h4B, 8'h4F, 8'h4E,
		8'h7B, 8'h50, 8'h4C, 8'h7D, 8'h3E, 8'h5B, 8'hBA, 8'h3C,
		8'h5F, 8'h60, 8'h5D, 8'h93, 8'h00, 8'h3D, 8'h5E, 8'h3F,
		8'h21, 8'h7E, 8'h00, 8'h22, 8'hA0, 8'h00, 8'h51, 8'h83
	};

endpackage

`default_nettype wire

// ===== design/mks_front.sv =====
`default_nettype none

module mks_front (
	input  wire logic [1:0]      func,
	input  wire logic            io_accessible,
	input  wire logic [7:0]      joystick_port,
	input  wire logic [63:0]     matrix,
	output mks_pkg::entry_t      entry
);
	import mks_pkg::*;

	logic       joy_active;
	logic       joy_hit;
	logic [5:0] joy_pos;
	logic [2:0] joy_mods;
	logic       kb_hit;
	logic [5:0] kb_pos;
	logic [2:0] kb_mods;
	logic       hit;
	logic [5:0] pos;
	logic [2:0] mods;
	logic [7:0] code;

	assign joy_active = (joystick_port != JOY_IDLE);

	// joystick bits 0..4 in priority order
	always_comb begin
		joy_hit  = 1'b1;
		joy_pos  = JOY_POS_UPDOWN;
		joy_mods = MOD_NONE;
		priority if (!joystick_port[0]) begin
			joy_pos  = JOY_POS_UPDOWN;
			joy_mods = MOD_SHIFT;
		end else if (!joystick_port[1]) begin
			joy_pos  = JOY_POS_UPDOWN;
		end else if (!joystick_port[2]) begin
			joy_pos  = JOY_POS_LEFTRIGHT;
			joy_mods = MOD_SHIFT;
		end else if (!joystick_port[3]) begin
			joy_pos  = JOY_POS_LEFTRIGHT;
		end else if (!joystick_port[4]) begin
			joy_pos  = JOY_POS_FIRE;
		end else begin
			joy_hit  = 1'b0;
		end
	end

	// highest pressed non-modifier position, modifiers ORed
	always_comb begin
		kb_hit  = 1'b0;
		kb_pos  = '0;
		kb_mods = MOD_NONE;
		for (int i = 0; i < 64; i++) begin
			if (!matrix[i]) begin
				kb_mods = kb_mods | MOD_BITS[i];
				if (MOD_BITS[i] == MOD_NONE) begin
					kb_hit = 1'b1;
					kb_pos = 6'(i);
				end
			end
		end
	end

	assign hit  = joy_active ? joy_hit  : kb_hit;
	assign pos  = joy_active ? joy_pos  : kb_pos;
	assign mods = joy_active ? joy_mods : kb_mods;
	assign code = (mods != MOD_NONE) ? SHIFT_CODES[pos] : PLAIN_CODES[pos];

	always_comb begin
		entry.pos  = pos;
		entry.mods = mods;
		entry.code = code;
		unique case (func)
			FUNC_SCAN: begin
				if (!io_accessible)
					entry.cmd = CMD_NOP;
				else if (hit && code != 8'h00)
					entry.cmd = CMD_KEY;
				else
					entry.cmd = CMD_FORGET;
			end
			FUNC_POP:   entry.cmd = CMD_POP;
			FUNC_CLEAR: entry.cmd = CMD_CLEAR;
			default:    entry.cmd = CMD_NOP;
		endcase
	end

endmodule

`default_nettype wire

// ===== design/mks_queue.sv =====
`default_nettype none

module mks_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire mks_pkg::entry_t push_data,
	output logic                 not_full,
	input  wire logic            pop,
	output logic                 not_empty,
	output mks_pkg::entry_t      pop_data
);
	import mks_pkg::*;

	entry_t     slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign not_full  = (count_q != 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign pop_data  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push && not_full)
			slot_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push && not_full)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop && not_empty)
				rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + 2'(push && not_full) - 2'(pop && not_empty);
		end
	end

endmodule

`default_nettype wire

// ===== design/mks_back.sv =====
`default_nettype none

module mks_back #(
	parameter int BUFFER_DEPTH = 16
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            write_enable,
	input  wire logic            reg_index,
	input  wire logic [7:0]      write_data,
	input  wire logic            q_valid,
	input  wire mks_pkg::entry_t q_data,
	output logic                 q_pop,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output logic                 key_valid,
	output logic [7:0]           key_code,
	output logic [4:0]           queued_keys,
	output logic                 key_pushed,
	output logic                 key_dropped
);
	import mks_pkg::*;

	localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
	localparam int CW = $clog2(BUFFER_DEPTH + 1);
	localparam logic [AW-1:0] LAST_IDX = AW'(BUFFER_DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(BUFFER_DEPTH);

	logic [7:0]    delay_q;
	logic [7:0]    interval_q;
	logic [7:0]    last_pos_q;
	logic [7:0]    last_mod_q;
	logic [7:0]    countdown_q;
	logic [AW-1:0] head_q;
	logic [AW-1:0] tail_q;
	logic [CW-1:0] count_q;
	logic [7:0]    key_store [BUFFER_DEPTH];
	logic [7:0]    rd_data_q;

	logic          out_valid_q;
	logic          key_valid_q;
	logic          pushed_q;
	logic          dropped_q;

	logic          fire;
	logic          same_pos;
	logic          same_mod;
	logic          produce;
	logic          push;
	logic          drop;
	logic          pop_hit;
	logic [7:0]    last_pos_d;
	logic [7:0]    last_mod_d;
	logic [7:0]    countdown_d;
	logic [AW-1:0] head_d;
	logic [AW-1:0] tail_d;
	logic [CW-1:0] count_d;
	logic [CW+4:0] count_ext;

	assign fire  = q_valid && (!out_valid_q || out_ready);
	assign q_pop = fire;

	assign same_pos = (last_pos_q == {2'b00, q_data.pos});
	assign same_mod = (last_mod_q == {5'b00000, q_data.mods});

	always_comb begin
		last_pos_d  = last_pos_q;
		last_mod_d  = last_mod_q;
		countdown_d = countdown_q;
		head_d      = head_q;
		tail_d      = tail_q;
		count_d     = count_q;
		produce     = 1'b0;
		pop_hit     = 1'b0;
		unique case (q_data.cmd)
			CMD_FORGET: begin
				last_pos_d = NO_KEY;
				last_mod_d = NO_KEY;
			end
			CMD_KEY: begin
				if (same_pos && same_mod) begin
					if (countdown_q == 8'd0) begin
						countdown_d = interval_q;
						produce     = 1'b1;
					end else begin
						countdown_d = countdown_q - 8'd1;
					end
				end else if (same_pos) begin
					// modifier change on the held key: re-arm only
					countdown_d = delay_q;
					last_mod_d  = {5'b00000, q_data.mods};
				end else begin
					countdown_d = delay_q;
					last_pos_d  = {2'b00, q_data.pos};
					last_mod_d  = {5'b00000, q_data.mods};
					produce     = 1'b1;
				end
			end
			CMD_POP: begin
				if (count_q != '0) begin
					pop_hit = 1'b1;
					head_d  = (head_q == LAST_IDX) ? '0 : head_q + AW'(1);
					count_d = count_q - CW'(1);
				end
			end
			CMD_CLEAR: begin
				head_d  = '0;
				tail_d  = '0;
				count_d = '0;
			end
			default: ;
		endcase
		push = produce && (count_q != FULL_CNT);
		drop = produce && (count_q == FULL_CNT);
		if (push) begin
			tail_d  = (tail_q == LAST_IDX) ? '0 : tail_q + AW'(1);
			count_d = count_q + CW'(1);
		end
	end

	// key buffer, registered read at the head
	always_ff @(posedge clk) begin
		if (fire && push)
			key_store[tail_q] <= q_data.code;
		if (fire)
			rd_data_q <= key_store[head_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q     <= INITIAL_DELAY_RESET;
			interval_q  <= REPEAT_INTERVAL_RESET;
		end else if (write_enable) begin
			unique case (reg_index)
				REG_INITIAL_DELAY:   delay_q    <= write_data;
				REG_REPEAT_INTERVAL: interval_q <= write_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_pos_q  <= NO_KEY;
			last_mod_q  <= NO_KEY;
			countdown_q <= INITIAL_DELAY_RESET;
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			key_valid_q <= 1'b0;
			pushed_q    <= 1'b0;
			dropped_q   <= 1'b0;
		end else begin
			if (fire) begin
				last_pos_q  <= last_pos_d;
				last_mod_q  <= last_mod_d;
				countdown_q <= countdown_d;
				head_q      <= head_d;
				tail_q      <= tail_d;
				count_q     <= count_d;
				key_valid_q <= pop_hit;
				pushed_q    <= push;
				dropped_q   <= drop;
			end
			if (fire)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign count_ext   = (CW + 5)'(count_q);
	assign out_valid   = out_valid_q;
	assign key_valid   = key_valid_q;
	assign key_code    = key_valid_q ? rd_data_q : 8'h00;
	assign queued_keys = count_ext[4:0];
	assign key_pushed  = pushed_q;
	assign key_dropped = dropped_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("key buffer count beyond depth");

	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (head_q == tail_q))
		else $error("empty buffer with head and tail apart");

	a_push_xor_drop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(pushed_q && dropped_q))
		else $error("beat flagged both pushed and dropped");

	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && pop_hit) |=> (count_q == $past(count_q) - CW'(1)))
		else $error("pop did not lower the count");

	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && drop) |=> (count_q == FULL_CNT))
		else $error("drop while buffer not full");

endmodule

`default_nettype wire

// ===== design/matrix_keyboard_typematic_scanner_top.sv =====
// Keyboard matrix scanner with typematic auto-repeat and a key code buffer.
//
// Input channel (in_valid/in_ready): one beat is a command. func selects a
// scan tick (joystick byte plus eight active-low row bytes), a pop of one
// key code, or a clear of the buffer. Output channel (out_valid/out_ready):
// exactly one result beat per input beat, in order.
// Config port: write_enable/reg_index/write_data, index 0 initial delay,
// index 1 repeat interval, taken on any edge with write_enable high. Write
// only while no beat is in flight.
// A beat waits in the two-entry queue and is registered into the output
// register once that register is free. Throughput: one beat per cycle unless
// a stalled receiver holds the output register; the front classifier is pure
// logic, the back applies the repeat state and buffer update once per cycle.
// Reset: no key held, countdown at 16, buffer empty, delay 16, interval 4.
// A stalled receiver holds the output register; the two-entry queue between
// front and back then takes up to two beats behind it and in_ready drops.
`default_nettype none

module matrix_keyboard_typematic_scanner_top #(
	parameter int BUFFER_DEPTH = 16
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	// config write port
	input  wire logic       write_enable,
	input  wire logic       reg_index,
	input  wire logic [7:0] write_data,
	// command beats
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [1:0] func,
	input  wire logic       io_accessible,
	input  wire logic [7:0] joystick_port,
	input  wire logic [7:0] row_col0,
	input  wire logic [7:0] row_col1,
	input  wire logic [7:0] row_col2,
	input  wire logic [7:0] row_col3,
	input  wire logic [7:0] row_col4,
	input  wire logic [7:0] row_col5,
	input  wire logic [7:0] row_col6,
	input  wire logic [7:0] row_col7,
	// result beats
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic            key_valid,
	output logic [7:0]      key_code,
	output logic [4:0]      queued_keys,
	output logic            key_pushed,
	output logic            key_dropped
);
	import mks_pkg::*;

	logic [63:0] matrix;
	entry_t      front_entry;
	entry_t      q_data;
	logic        q_valid;
	logic        q_pop;

	// bit x of row_colY is matrix position 8*Y+x
	assign matrix = {row_col7, row_col6, row_col5, row_col4,
	                 row_col3, row_col2, row_col1, row_col0};

	// front: decode the scan into position, modifiers and key code
	mks_front u_front (
		.func          (func),
		.io_accessible (io_accessible),
		.joystick_port (joystick_port),
		.matrix        (matrix),
		.entry         (front_entry)
	);

	// decoupling queue, lets front and back stall independently
	mks_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_valid),
		.push_data (front_entry),
		.not_full  (in_ready),
		.pop       (q_pop),
		.not_empty (q_valid),
		.pop_data  (q_data)
	);

	// back: repeat timing, key buffer and output register
	mks_back #(
		.BUFFER_DEPTH (BUFFER_DEPTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.write_enable (write_enable),
		.reg_index    (reg_index),
		.write_data   (write_data),
		.q_valid      (q_valid),
		.q_data       (q_data),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.key_valid    (key_valid),
		.key_code     (key_code),
		.queued_keys  (queued_keys),
		.key_pushed   (key_pushed),
		.key_dropped  (key_dropped)
	);

endmodule

`default_nettype wire

// ===== sim/keyscan_checker.sv =====
// Watches both channels of the scanner, keeps its own copy of the typematic
// state and key buffer, and compares every result beat against the oldest
// predicted one.
module keyscan_checker #(
	parameter int BUFFER_DEPTH = 16
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       write_enable,
	input  wire logic       reg_index,
	input  wire logic [7:0] write_data,
	input  wire logic       in_valid,
	input  wire logic       in_ready,
	input  wire logic [1:0] func,
	input  wire logic       io_accessible,
	input  wire logic [7:0] joystick_port,
	input  wire logic [7:0] row_col0,
	input  wire logic [7:0] row_col1,
	input  wire logic [7:0] row_col2,
	input  wire logic [7:0] row_col3,
	input  wire logic [7:0] row_col4,
	input  wire logic [7:0] row_col5,
	input  wire logic [7:0] row_col6,
	input  wire logic [7:0] row_col7,
	input  wire logic       out_valid,
	input  wire logic       out_ready,
	input  wire logic       key_valid,
	input  wire logic [7:0] key_code,
	input  wire logic [4:0] queued_keys,
	input  wire logic       key_pushed,
	input  wire logic       key_dropped,
	output int              mismatch_count,
	output int              results_owed
);
	import mks_pkg::*;

	localparam logic [7:0] NO_POSITION = 8'h40;

	typedef enum {SCAN_NONE, SCAN_PUSHED, SCAN_DROPPED} scan_outcome_t;

	typedef struct packed {
		logic       key_valid;
		logic [7:0] key_code;
		logic [4:0] queued_keys;
		logic       key_pushed;
		logic       key_dropped;
	} key_result_t;

	logic [7:0] delay_ticks;
	logic [7:0] interval_ticks;
	logic [7:0] held_pos;
	logic [7:0] held_mods;
	logic [7:0] countdown;
	logic [7:0] code_ring [BUFFER_DEPTH];
	int ring_head;
	int ring_count;
	int result_beats;
	key_result_t owed_key_results [$];

	task automatic report_mismatch(input string msg);
		$display("[%0t] result beat %0d: %s", $time, result_beats, msg);
		mismatch_count++;
	endtask

	function automatic void forget_held();
		held_pos = NO_KEY;
		held_mods = NO_KEY;
	endfunction

	function automatic scan_outcome_t scan_tick(input logic [7:0] joy, input logic [63:0] matrix);
		logic [7:0] pos;
		logic [7:0] mods;
		logic [7:0] code;
		int i;
		pos = NO_POSITION;
		mods = '0;
		if (joy != JOY_IDLE) begin
			// joystick bits in priority order; none of 0..4 low leaves pos empty
			if (!joy[0]) begin
				mods = {5'd0, MOD_SHIFT};
				pos = {2'd0, JOY_POS_UPDOWN};
			end else if (!joy[1]) begin
				mods = {5'd0, MOD_NONE};
				pos = {2'd0, JOY_POS_UPDOWN};
			end else if (!joy[2]) begin
				mods = {5'd0, MOD_SHIFT};
				pos = {2'd0, JOY_POS_LEFTRIGHT};
			end else if (!joy[3]) begin
				mods = {5'd0, MOD_NONE};
				pos = {2'd0, JOY_POS_LEFTRIGHT};
			end else if (!joy[4]) begin
				mods = {5'd0, MOD_NONE};
				pos = {2'd0, JOY_POS_FIRE};
			end
		end else begin
			if (&matrix) begin
				forget_held();
				return SCAN_NONE;
			end
			for (i = 0; i < 64; i++) begin
				if (!matrix[i]) begin
					mods = mods | {5'd0, MOD_BITS[i]};
					if (MOD_BITS[i] == MOD_NONE)
						pos = i[7:0];
				end
			end
		end

		if (pos >= NO_POSITION)
			code = '0;
		else if (mods != '0)
			code = SHIFT_CODES[pos[5:0]];
		else
			code = PLAIN_CODES[pos[5:0]];

		if (code == '0) begin
			forget_held();
			return SCAN_NONE;
		end

		if (mods == held_mods && pos == held_pos) begin
			if (countdown == '0) begin
				countdown = interval_ticks;
			end else begin
				countdown = countdown - 8'd1;
				return SCAN_NONE;
			end
		end else if (pos == held_pos) begin
			// same key, modifiers changed: re-arm only
			countdown = delay_ticks;
			held_mods = mods;
			return SCAN_NONE;
		end else begin
			countdown = delay_ticks;
			held_pos = pos;
			held_mods = mods;
		end

		if (ring_count >= BUFFER_DEPTH)
			return SCAN_DROPPED;
		code_ring[(ring_head + ring_count) % BUFFER_DEPTH] = code;
		ring_count++;
		return SCAN_PUSHED;
	endfunction

	function automatic key_result_t predict_beat(input logic [1:0] f, input logic io,
			input logic [7:0] joy, input logic [63:0] matrix);
		key_result_t r;
		scan_outcome_t o;
		r = '0;
		case (f)
			FUNC_SCAN: begin
				if (io) begin
					o = scan_tick(joy, matrix);
					r.key_pushed = (o == SCAN_PUSHED);
					r.key_dropped = (o == SCAN_DROPPED);
				end
			end
			FUNC_POP: begin
				if (ring_count > 0) begin
					r.key_valid = 1'b1;
					r.key_code = code_ring[ring_head];
					ring_head = (ring_head + 1) % BUFFER_DEPTH;
					ring_count--;
				end
			end
			FUNC_CLEAR: begin
				ring_count = 0;
				ring_head = 0;
			end
			default: ;
		endcase
		r.queued_keys = ring_count[4:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		key_result_t want;
		if (!arst_n) begin
			delay_ticks = INITIAL_DELAY_RESET;
			interval_ticks = REPEAT_INTERVAL_RESET;
			held_pos = NO_KEY;
			held_mods = NO_KEY;
			countdown = INITIAL_DELAY_RESET;
			ring_head = 0;
			ring_count = 0;
			result_beats = 0;
			mismatch_count = 0;
			owed_key_results.delete();
			results_owed = 0;
		end else begin
			if (write_enable) begin
				if (reg_index == REG_INITIAL_DELAY)
					delay_ticks = write_data;
				else
					interval_ticks = write_data;
			end

			// results first: a beat taken at this edge cannot answer itself
			if (out_valid && out_ready) begin
				if (owed_key_results.size() == 0) begin
					report_mismatch("result beat with nothing outstanding");
				end else begin
					want = owed_key_results.pop_front();
					if (key_valid !== want.key_valid)
						report_mismatch($sformatf("key_valid %b, want %b", key_valid,
							want.key_valid));
					if (key_code !== want.key_code)
						report_mismatch($sformatf("key_code %h, want %h", key_code,
							want.key_code));
					if (queued_keys !== want.queued_keys)
						report_mismatch($sformatf("queued_keys %0d, want %0d", queued_keys,
							want.queued_keys));
					if (key_pushed !== want.key_pushed)
						report_mismatch($sformatf("key_pushed %b, want %b", key_pushed,
							want.key_pushed));
					if (key_dropped !== want.key_dropped)
						report_mismatch($sformatf("key_dropped %b, want %b", key_dropped,
							want.key_dropped));
				end
				result_beats++;
			end

			if (in_valid && in_ready)
				owed_key_results.push_back(predict_beat(func, io_accessible, joystick_port,
					{row_col7, row_col6, row_col5, row_col4,
					 row_col3, row_col2, row_col1, row_col0}));

			results_owed = owed_key_results.size();
		end
	end

endmodule

// ===== sim/matrix_keyboard_typematic_scanner_top_tb.sv =====
// Top of the scanner regression: clock, reset, config writes, command beats
// and a randomly stalling receiver. All checking lives in keyscan_checker.
module matrix_keyboard_typematic_scanner_top_tb;
	import mks_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	// receiver hold-off length, long enough to back up the whole pipeline
	localparam int HOLD_CYCLES = 80;
	localparam int PHASES = 7;
	// func code 3 has no meaning; the block must pass it through untouched
	localparam logic [1:0] FUNC_UNUSED = 2'd3;

	// register settings per phase; extremes first, then a mix of small, extreme and typical values
	localparam logic [7:0] PHASE_DELAY    [PHASES] = '{8'd0, 8'd255, 8'd1, 8'd3, 8'd0, 8'd8, 8'd16};
	localparam logic [7:0] PHASE_INTERVAL [PHASES] = '{8'd0, 8'd255, 8'd0, 8'd2, 8'd255, 8'd1, 8'd4};

	// one command beat; matrix bit 8*Y+x is bit x of row_colY
	typedef struct {
		logic [1:0]  func;
		logic        io;
		logic [7:0]  joy;
		logic [63:0] matrix;
	} scan_beat_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       write_enable = 1'b0;
	logic       reg_index = 1'b0;
	logic [7:0] write_data = '0;
	logic       in_valid = 1'b0;
	logic [1:0] func = FUNC_SCAN;
	logic       io_accessible = 1'b0;
	logic [7:0] joystick_port = JOY_IDLE;
	logic [7:0] row_col0 = ROW_IDLE;
	logic [7:0] row_col1 = ROW_IDLE;
	logic [7:0] row_col2 = ROW_IDLE;
	logic [7:0] row_col3 = ROW_IDLE;
	logic [7:0] row_col4 = ROW_IDLE;
	logic [7:0] row_col5 = ROW_IDLE;
	logic [7:0] row_col6 = ROW_IDLE;
	logic [7:0] row_col7 = ROW_IDLE;
	logic       out_ready = 1'b0;

	logic       in_ready;
	logic       out_valid;
	logic       key_valid;
	logic [7:0] key_code;
	logic [4:0] queued_keys;
	logic       key_pushed;
	logic       key_dropped;

	int mismatch_count;
	int results_owed;

	// shared knobs between the sender and the receiver process
	bit no_idle = 1'b0;
	int hold_requests = 0;
	int holds_served = 0;
	int beats_sent = 0;

	always #2 clk = ~clk;

	matrix_keyboard_typematic_scanner_top #(
		.BUFFER_DEPTH(16)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.write_enable (write_enable),
		.reg_index    (reg_index),
		.write_data   (write_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.func         (func),
		.io_accessible(io_accessible),
		.joystick_port(joystick_port),
		.row_col0     (row_col0),
		.row_col1     (row_col1),
		.row_col2     (row_col2),
		.row_col3     (row_col3),
		.row_col4     (row_col4),
		.row_col5     (row_col5),
		.row_col6     (row_col6),
		.row_col7     (row_col7),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.key_valid    (key_valid),
		.key_code     (key_code),
		.queued_keys  (queued_keys),
		.key_pushed   (key_pushed),
		.key_dropped  (key_dropped)
	);

	keyscan_checker #(
		.BUFFER_DEPTH(16)
	) key_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.write_enable  (write_enable),
		.reg_index     (reg_index),
		.write_data    (write_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.func          (func),
		.io_accessible (io_accessible),
		.joystick_port (joystick_port),
		.row_col0      (row_col0),
		.row_col1      (row_col1),
		.row_col2      (row_col2),
		.row_col3      (row_col3),
		.row_col4      (row_col4),
		.row_col5      (row_col5),
		.row_col6      (row_col6),
		.row_col7      (row_col7),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.key_valid     (key_valid),
		.key_code      (key_code),
		.queued_keys   (queued_keys),
		.key_pushed    (key_pushed),
		.key_dropped   (key_dropped),
		.mismatch_count(mismatch_count),
		.results_owed  (results_owed)
	);

	// one pressed position, all others released (active low)
	function automatic logic [63:0] key_mask(input int p);
		return ~(64'd1 << p);
	endfunction

	// any position that is not a modifier
	function automatic int pick_key();
		int p;
		do
			p = $urandom_range(0, 63);
		while (MOD_BITS[p] != MOD_NONE);
		return p;
	endfunction

	// presses each modifier position with the given chance in percent
	function automatic logic [63:0] random_modifiers(input int pct);
		logic [63:0] m;
		int i;
		m = '1;
		for (i = 0; i < 64; i++)
			if (MOD_BITS[i] != MOD_NONE && $urandom_range(0, 99) < pct)
				m[i] = 1'b0;
		return m;
	endfunction

	function automatic scan_beat_t scan_of(input logic [7:0] joy, input logic [63:0] matrix);
		scan_beat_t b;
		b.func = FUNC_SCAN;
		b.io = 1'b1;
		b.joy = joy;
		b.matrix = matrix;
		return b;
	endfunction

	// any func with random junk on the fields it should not look at
	function automatic scan_beat_t command_of(input logic [1:0] f);
		scan_beat_t b;
		logic [31:0] r;
		r = $urandom;
		b.func = f;
		b.io = r[0];
		b.joy = r[15:8];
		b.matrix = {$urandom, $urandom};
		return b;
	endfunction

	// Offers one beat after a random gap and returns at the accepting edge.
	// With a zero gap valid stays high straight into the next beat.
	task automatic send_beat(input scan_beat_t b);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= b.func;
		io_accessible <= b.io;
		joystick_port <= b.joy;
		row_col0 <= b.matrix[7:0];
		row_col1 <= b.matrix[15:8];
		row_col2 <= b.matrix[23:16];
		row_col3 <= b.matrix[31:24];
		row_col4 <= b.matrix[39:32];
		row_col5 <= b.matrix[47:40];
		row_col6 <= b.matrix[55:48];
		row_col7 <= b.matrix[63:56];
		do
			@(posedge clk);
		while (!in_ready);
		beats_sent++;
	endtask

	// Sender pause: wait until every predicted result has come back, then
	// let the pipeline settle. The owed count is sampled on the falling edge.
	task automatic drain_results(input int settle);
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (results_owed != 0);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_registers(input logic [7:0] delay, input logic [7:0] interval);
		write_enable <= 1'b1;
		reg_index <= REG_INITIAL_DELAY;
		write_data <= delay;
		@(posedge clk);
		reg_index <= REG_REPEAT_INTERVAL;
		write_data <= interval;
		@(posedge clk);
		write_enable <= 1'b0;
	endtask

	// Receiver: random stall per beat, plus a long hold-off on request.
	initial begin
		int stall;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (holds_served < hold_requests) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				holds_served++;
			end
			stall = no_idle ? 0 : $urandom_range(0, 14);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do
				@(posedge clk);
			while (!out_valid);
		end
	end

	// Watchdog: covers a hung handshake as well as a lost result.
	initial begin
		int cycles;
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	initial begin
		scan_beat_t b;
		logic [63:0] keys;
		logic [63:0] mods;
		logic [7:0] joy;
		logic [31:0] r;
		int ph;
		int target;
		int held;
		int len;
		int turn;
		int i;
		int pick;
		bit hold_done;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ---- directed part, reset register values (delay 16, interval 4) ----
		send_beat(command_of(FUNC_POP));                 // pop on empty buffer
		send_beat(command_of(FUNC_UNUSED));              // unused func code
		send_beat(scan_of(JOY_IDLE, '1));                // nothing pressed
		b = scan_of(JOY_IDLE, key_mask(0));              // port not accessible
		b.io = 1'b0;
		send_beat(b);
		send_beat(scan_of(JOY_IDLE, key_mask(0)));       // new key, queued at once
		send_beat(scan_of(JOY_IDLE, key_mask(0)));       // held, counting down
		// same key plus left shift: re-arm, nothing queued
		send_beat(scan_of(JOY_IDLE, key_mask(0) & key_mask(15)));
		send_beat(scan_of(JOY_IDLE, key_mask(58)));      // modifier only
		send_beat(scan_of(JOY_IDLE, '0));                // whole matrix pressed
		// highest position wins, a modifier in the same row selects the shifted map
		send_beat(scan_of(JOY_IDLE, key_mask(3) & key_mask(60) & key_mask(61)));
		for (i = 0; i < 5; i++)                          // each joystick bit
			send_beat(scan_of(~(8'd1 << i), '1));
		send_beat(scan_of(8'h00, '1));                   // joystick all low
		send_beat(scan_of(8'h1F, '0));                   // joystick active, no bit 0..4
		send_beat(command_of(FUNC_POP));
		send_beat(command_of(FUNC_POP));
		send_beat(command_of(FUNC_CLEAR));
		send_beat(command_of(FUNC_POP));
		send_beat(scan_of(8'h7F, key_mask(20)));         // only bit 7 low
		send_beat(command_of(FUNC_CLEAR));

		// ---- random part, one register setting per phase ----
		for (ph = 0; ph < PHASES; ph++) begin
			drain_results(4);
			write_registers(PHASE_DELAY[ph], PHASE_INTERVAL[ph]);
			no_idle = (ph % 3 == 1);
			hold_done = 1'b0;

			if (ph == 0) begin
				// zero delay and interval: a held key queues every tick, so the
				// buffer fills and further codes are dropped
				held = pick_key();
				repeat (40) send_beat(scan_of(JOY_IDLE, key_mask(held)));
				send_beat(command_of(FUNC_POP));
				send_beat(command_of(FUNC_CLEAR));
			end

			target = 25 + (ph + 1) * 118;
			while (beats_sent < target) begin
				if (!hold_done && beats_sent >= target - 60) begin
					// receiver holds off while beats keep coming back to back
					hold_done = 1'b1;
					no_idle = 1'b1;
					hold_requests++;
					held = pick_key();
					repeat (12) send_beat(scan_of(JOY_IDLE, key_mask(held)));
					no_idle = (ph % 3 == 1);
				end

				pick = $urandom_range(0, 99);
				if (pick < 45) begin
					// held key, maybe with a second key and modifiers, maybe a
					// modifier change partway, pops and ignored scans mixed in
					keys = key_mask(pick_key());
					if ($urandom_range(0, 3) == 0)
						keys &= key_mask(pick_key());
					mods = ($urandom_range(0, 2) == 0) ? random_modifiers(50) : '1;
					len = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
						: $urandom_range(1, 20);
					turn = $urandom_range(0, len * 4);
					for (i = 0; i < len; i++) begin
						if (i == turn)
							mods = random_modifiers(50);
						if ($urandom_range(0, 99) < 30)
							send_beat(command_of(FUNC_POP));
						if ($urandom_range(0, 99) < 4) begin
							b = command_of(FUNC_SCAN);
							b.io = 1'b0;
							send_beat(b);
						end
						send_beat(scan_of(JOY_IDLE, keys & mods));
					end
				end else if (pick < 60) begin
					// held joystick direction or fire, other bits random
					joy = ~(8'd1 << $urandom_range(0, 4));
					if ($urandom_range(0, 2) == 0) begin
						r = $urandom;
						joy &= r[7:0];
					end
					keys = {$urandom, $urandom};
					len = $urandom_range(1, 30);
					for (i = 0; i < len; i++) begin
						if ($urandom_range(0, 99) < 30)
							send_beat(command_of(FUNC_POP));
						send_beat(scan_of(joy, keys));
					end
				end else if (pick < 75) begin
					repeat ($urandom_range(1, 3)) send_beat(scan_of(JOY_IDLE, '1));
				end else if (pick < 85) begin
					// noise: any func, random bytes, rows decide half the time
					r = $urandom;
					b = command_of(r[1:0]);
					if (r[2])
						b.joy = JOY_IDLE;
					send_beat(b);
				end else begin
					repeat ($urandom_range(1, 18)) send_beat(command_of(FUNC_POP));
					if ($urandom_range(0, 4) == 0)
						send_beat(command_of(FUNC_CLEAR));
				end
			end
		end

		drain_results(8);
		if (mismatch_count == 0 && results_owed == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== filelist.f =====
design/mks_pkg.sv
design/mks_front.sv
design/mks_queue.sv
design/mks_back.sv
design/matrix_keyboard_typematic_scanner_top.sv
sim/keyscan_checker.sv
sim/matrix_keyboard_typematic_scanner_top_tb.sv
